// ----- rtl/core/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transaction sequencer: the
// input and result words, the mode, status, action and end-cause codes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Data store geometry
  localparam int unsigned BufDepth = 32;
  localparam int unsigned CntW     = 6;   // holds 0..BufDepth
  localparam int unsigned IdxW     = 5;   // addresses 0..BufDepth-1

  // Item modes
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_EVENT = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // Status is compared with its low three bits cleared
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_TX_ACK    = 8'h28;
  localparam logic [7:0] ST_TX_NACK   = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  // Bus actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_SEND  = 3'd3;
  localparam logic [2:0] ACT_RACK  = 3'd4;
  localparam logic [2:0] ACT_RNACK = 3'd5;

  // End causes, reported with advance
  localparam logic [1:0] END_DONE = 2'd0;
  localparam logic [1:0] END_ADDR = 2'd1;
  localparam logic [1:0] END_DATA = 2'd2;
  localparam logic [1:0] END_ODD  = 2'd3;

  typedef struct packed {
    logic [1:0]      mode;
    logic [7:0]      status;
    logic [7:0]      rx_byte;
    logic            pending;
    logic [6:0]      slave_addr;
    logic            read_not_write;
    logic [CntW-1:0] length;
    logic [IdxW-1:0] load_index;
    logic [7:0]      load_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [7:0]      tx_byte;
    logic            advance;
    logic            busy_res;
    logic            rx_valid;
    logic [IdxW-1:0] rx_index;
    logic [7:0]      captured_byte;
    logic [1:0]      end_cause;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2c_master_transaction_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_core
// Turns poll, bus status and store load words into the next I2C bus action,
// keeping the busy flag, the byte counter and a 32-byte data store.
// ----------------------------------------------------------------------------
// Each word is first held in the input register; then the decode, counter
// update and data store access run in one combinational pass into the
// result register. A new word is accepted every cycle; the input side
// stalls only while the result register is full and the downstream side
// stalls it. The data store is a flip-flop array without reset, so entries
// read before being loaded or received hold unknown data.
`default_nettype none

module i2c_master_transaction_sequencer_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire i2cms_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output i2cms_pkg::out_word_t      out_word_o
);
  import i2cms_pkg::*;

  // Pipeline registers
  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  out_word_t out_q;
  out_word_t res;

  // Sequencer state
  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      store_q [BufDepth];

  logic            store_we;
  logic [IdxW-1:0] store_wa;
  logic [7:0]      store_wd;

  logic            out_free;
  logic            fire;

  // Decode helpers
  logic [7:0]      st;
  logic [CntW-1:0] len_sat;
  logic [CntW:0]   cnt_inc;
  logic [CntW-1:0] cnt_rx;
  logic [CntW:0]   cnt_rx_inc;
  logic            cnt_in_range;
  logic            finish;
  logic [1:0]      cause;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  assign st           = in_q.status & ST_MASK;
  assign len_sat      = (in_q.length > CntW'(BufDepth)) ? CntW'(BufDepth) : in_q.length;
  assign cnt_in_range = cnt_q < CntW'(BufDepth);
  assign cnt_inc      = {1'b0, cnt_q} + (CntW+1)'(1);
  assign cnt_rx       = cnt_in_range ? cnt_inc[CntW-1:0] : cnt_q;
  assign cnt_rx_inc   = {1'b0, cnt_rx} + (CntW+1)'(1);

  // Decode the word against the current state
  always_comb begin
    res           = '0;
    res.action    = ACT_NONE;
    busy_d        = busy_q;
    cnt_d         = cnt_q;
    store_we      = 1'b0;
    store_wa      = in_q.load_index;
    store_wd      = in_q.load_byte;
    finish        = 1'b0;
    cause         = END_DONE;

    unique case (in_q.mode)
      MODE_POLL: begin
        if (!busy_q && in_q.pending) begin
          res.action = ACT_START;
          busy_d     = 1'b1;
        end
      end
      MODE_LOAD: begin
        store_we = 1'b1;
      end
      MODE_EVENT: begin
        unique case (st)
          ST_START, ST_RSTART: begin
            res.action  = ACT_SEND;
            res.tx_byte = {in_q.slave_addr, in_q.read_not_write};
          end
          ST_SLAW_ACK: begin
            res.action  = ACT_SEND;
            res.tx_byte = store_q[0];
            cnt_d       = CntW'(1);
          end
          ST_SLAW_NACK, ST_SLAR_NACK: begin
            finish = 1'b1;
            cause  = END_ADDR;
          end
          ST_TX_ACK: begin
            if (cnt_q >= len_sat) begin
              finish = 1'b1;
            end else begin
              res.action  = ACT_SEND;
              res.tx_byte = store_q[cnt_q[IdxW-1:0]];
              cnt_d       = cnt_inc[CntW-1:0];
            end
          end
          ST_TX_NACK: begin
            finish = 1'b1;
            cause  = (cnt_q == len_sat) ? END_DONE : END_DATA;
          end
          ST_SLAR_ACK: begin
            res.action = (cnt_inc == {1'b0, len_sat}) ? ACT_RNACK : ACT_RACK;
          end
          ST_RX_ACK, ST_RX_NACK: begin
            // Report the byte always; store it only while it fits
            res.rx_index      = cnt_q[IdxW-1:0];
            res.captured_byte = in_q.rx_byte;
            res.rx_valid      = cnt_in_range;
            store_we          = cnt_in_range;
            store_wa          = cnt_q[IdxW-1:0];
            store_wd          = in_q.rx_byte;
            if (st == ST_RX_NACK) begin
              finish = 1'b1;
            end else begin
              cnt_d      = cnt_rx;
              res.action = (cnt_rx_inc == {1'b0, len_sat}) ? ACT_RNACK : ACT_RACK;
            end
          end
          default: begin
            finish = 1'b1;
            cause  = END_ODD;
          end
        endcase
        // Every stop path advances the instruction queue
        if (finish) begin
          res.action    = ACT_STOP;
          res.advance   = 1'b1;
          res.end_cause = cause;
          cnt_d         = '0;
          busy_d        = 1'b0;
        end else begin
          busy_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.busy_res = busy_d;
  end

  // Commit state when the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (fire) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && store_we) begin
      store_q[store_wa] <= store_wd;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A stop is the only action that advances the queue
  a_adv_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.advance |-> out_word_o.action == ACT_STOP)
    else $error("advance without stop");

  // An end cause is only reported with advance
  a_cause_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.end_cause != END_DONE |-> out_word_o.advance)
    else $error("end cause without advance");

  // Advancing always leaves the bus idle with a cleared counter
  a_adv_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.advance |=> !busy_q && cnt_q == '0)
    else $error("state not cleared after advance");

  // The byte counter never passes the store depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufDepth))
    else $error("byte counter out of range");

  // A word blocked behind a full result register stays in the input stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q)
    else $error("input word lost under stall");

endmodule

`default_nettype wire

// ----- test/i2cms_seq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cms_seq_checker
// Watches both word channels of the I2C master transaction sequencer core,
// predicts the result word of every accepted input word from its own copy
// of the busy flag, byte counter and data store, and compares each accepted
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module i2cms_seq_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  i2cms_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  i2cms_pkg::out_word_t out_word_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          words_waiting_o
);

  import i2cms_pkg::*;

  // Shadow state of the sequencer
  logic            busy_q;
  logic [CntW-1:0] count_q;
  logic [7:0]      store_q [BufDepth];

  out_word_t predicted_actions [$];

  // Work out the result word of one input word and advance the shadow state
  function automatic out_word_t next_bus_action(input in_word_t w);
    out_word_t   r;
    logic [7:0]  st;
    int unsigned eff_len;
    bit          stop_now;
    r        = '0;
    stop_now = 1'b0;
    st       = w.status & ST_MASK;
    eff_len  = (w.length > BufDepth) ? BufDepth : w.length;
    case (w.mode)
      MODE_POLL: begin
        if (!busy_q && w.pending) begin
          r.action = ACT_START;
          busy_q   = 1'b1;
        end
      end
      MODE_LOAD: begin
        store_q[w.load_index] = w.load_byte;
      end
      MODE_EVENT: begin
        case (st)
          ST_START, ST_RSTART: begin
            r.action  = ACT_SEND;
            r.tx_byte = {w.slave_addr, w.read_not_write};
          end
          ST_SLAW_ACK: begin
            r.action  = ACT_SEND;
            r.tx_byte = store_q[0];
            count_q   = 1;
          end
          ST_SLAW_NACK, ST_SLAR_NACK: begin
            stop_now    = 1'b1;
            r.end_cause = END_ADDR;
          end
          ST_TX_ACK: begin
            // at-least compare: a count past the length also ends the write
            if (count_q >= eff_len) begin
              stop_now    = 1'b1;
              r.end_cause = END_DONE;
            end else begin
              r.action  = ACT_SEND;
              r.tx_byte = store_q[count_q[IdxW-1:0]];
              count_q   = count_q + 1'b1;
            end
          end
          ST_TX_NACK: begin
            stop_now    = 1'b1;
            r.end_cause = (count_q == eff_len) ? END_DONE : END_DATA;
          end
          ST_SLAR_ACK: begin
            r.action = (count_q + 1 == eff_len) ? ACT_RNACK : ACT_RACK;
          end
          ST_RX_ACK, ST_RX_NACK: begin
            // report the byte always, store it only while the index fits
            r.rx_index      = count_q[IdxW-1:0];
            r.captured_byte = w.rx_byte;
            if (count_q < BufDepth) begin
              store_q[count_q[IdxW-1:0]] = w.rx_byte;
              r.rx_valid = 1'b1;
            end
            if (st == ST_RX_NACK) begin
              stop_now    = 1'b1;
              r.end_cause = END_DONE;
            end else begin
              if (count_q < BufDepth) count_q = count_q + 1'b1;
              r.action = (count_q + 1 == eff_len) ? ACT_RNACK : ACT_RACK;
            end
          end
          default: begin
            stop_now    = 1'b1;
            r.end_cause = END_ODD;
          end
        endcase
        if (stop_now) begin
          r.action  = ACT_STOP;
          r.advance = 1'b1;
          count_q   = '0;
          busy_q    = 1'b0;
        end else begin
          busy_q = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.busy_res = busy_q;
    return r;
  endfunction

  function automatic string word_text(input out_word_t w);
    return $sformatf("act=%0d tx=%02h adv=%0d busy=%0d rxv=%0d rxi=%0d cap=%02h end=%0d",
                     w.action, w.tx_byte, w.advance, w.busy_res, w.rx_valid,
                     w.rx_index, w.captured_byte, w.end_cause);
  endfunction

  // Retire result words first, then queue the prediction for a new input word
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t got;
    out_word_t want;
    string     bad;
    if (!rst_ni) begin
      busy_q  = 1'b0;
      count_q = '0;
      predicted_actions.delete();
      words_waiting_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_word_i;
        if (predicted_actions.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected result word: %s", $time, word_text(got));
          mismatch_count_o++;
        end else begin
          want = predicted_actions.pop_front();
          bad  = "";
          if (got.action        !== want.action)        bad = {bad, " action"};
          if (got.tx_byte       !== want.tx_byte)       bad = {bad, " tx_byte"};
          if (got.advance       !== want.advance)       bad = {bad, " advance"};
          if (got.busy_res      !== want.busy_res)      bad = {bad, " busy_res"};
          if (got.rx_valid      !== want.rx_valid)      bad = {bad, " rx_valid"};
          if (got.rx_index      !== want.rx_index)      bad = {bad, " rx_index"};
          if (got.captured_byte !== want.captured_byte) bad = {bad, " captured_byte"};
          if (got.end_cause     !== want.end_cause)     bad = {bad, " end_cause"};
          if (bad != "") begin
            if (mismatch_count_o < 10) begin
              $display("%0t: mismatch in%s", $time, bad);
              $display("  expected %s", word_text(want));
              $display("  actual   %s", word_text(got));
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predicted_actions.push_back(next_bus_action(in_word_i));
      words_waiting_o <= predicted_actions.size();
    end
  end

endmodule

// ----- test/i2c_master_transaction_sequencer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_core_tb
// Drives the sequencer core with a store fill, a short directed run of the
// bus status corner cases, then random write and read transfers mixed with
// noise words, under three idle and stall patterns. A checker module beside
// the core predicts and compares every result word.
// ----------------------------------------------------------------------------

module i2c_master_transaction_sequencer_core_tb;

  import i2cms_pkg::*;

  localparam int         CLK_PERIOD = 8;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  int unsigned mismatch_count;
  int unsigned words_waiting;

  int src_idle_pct  = 21;
  int sink_idle_pct = 46;
  int items_sent    = 0;

  // Current instruction as the queue would present it
  logic [6:0]      cur_addr;
  logic            cur_rnw;
  logic [CntW-1:0] cur_len;

  i2c_master_transaction_sequencer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  i2cms_seq_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_word_i       (in_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_i      (out_word_o),
    .mismatch_count_o(mismatch_count),
    .words_waiting_o (words_waiting)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_idle_pct);
  end

  // Give up after a generous bound
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_word_t rand_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t event_word(input logic [7:0] st);
    in_word_t w;
    w                = rand_word();
    w.mode           = MODE_EVENT;
    w.status         = st | 8'($urandom_range(7));
    w.slave_addr     = cur_addr;
    w.read_not_write = cur_rnw;
    w.length         = cur_len;
    return w;
  endfunction

  function automatic in_word_t poll_word(input logic pend);
    in_word_t w;
    w         = rand_word();
    w.mode    = MODE_POLL;
    w.pending = pend;
    return w;
  endfunction

  function automatic in_word_t load_word(input logic [IdxW-1:0] idx, input logic [7:0] b);
    in_word_t w;
    w            = rand_word();
    w.mode       = MODE_LOAD;
    w.load_index = idx;
    w.load_byte  = b;
    return w;
  endfunction

  task automatic set_instr(input logic [6:0] a, input logic rnw, input logic [CntW-1:0] len);
    cur_addr = a;
    cur_rnw  = rnw;
    cur_len  = len;
  endtask

  // Offer one word, idling first at random; return once it is taken
  task automatic send_word(input in_word_t w);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // One transfer: poll, start, address phase, then data until a stop
  task automatic run_transfer();
    int k;
    int n;
    int eff_len;
    k = $urandom_range(9);
    cur_addr = 7'($urandom_range(127));
    cur_rnw  = 1'($urandom_range(1));
    cur_len  = (k < 7) ? CntW'($urandom_range(6)) :
               (k < 9) ? CntW'($urandom_range(32, 7)) : CntW'($urandom_range(63, 33));
    eff_len  = (cur_len > BufDepth) ? BufDepth : cur_len;
    if (!cur_rnw)
      repeat ($urandom_range(3)) send_word(load_word(IdxW'($urandom_range(31)),
                                                     8'($urandom_range(255))));
    send_word(poll_word($urandom_range(9) != 0));
    send_word(event_word($urandom_range(1) ? ST_START : ST_RSTART));
    // break off with some odd status now and then
    if ($urandom_range(19) == 0) begin
      send_word(event_word(8'($urandom_range(255))));
      return;
    end
    if (!cur_rnw) begin
      if ($urandom_range(9) == 0) begin
        send_word(event_word(ST_SLAW_NACK));
        return;
      end
      send_word(event_word(ST_SLAW_ACK));
      for (k = 1; k <= BufDepth + 1; k++) begin
        if ($urandom_range(11) == 0) begin
          send_word(event_word(ST_TX_NACK));
          return;
        end
        send_word(event_word(ST_TX_ACK));
        if (k >= eff_len) return;
      end
    end else begin
      if ($urandom_range(9) == 0) begin
        send_word(event_word(ST_SLAR_NACK));
        return;
      end
      send_word(event_word(ST_SLAR_ACK));
      n = ($urandom_range(7) == 0) ? $urandom_range(40) : ((eff_len > 0) ? eff_len - 1 : 0);
      repeat (n) send_word(event_word(ST_RX_ACK));
      send_word(event_word(ST_RX_NACK));
    end
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct, input int quota);
    int stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(2) == 0) repeat ($urandom_range(3, 1)) send_word(rand_word());
      run_transfer();
    end
  endtask

  initial begin : stimulus
    in_word_t w;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole store so no entry is read before it is written
    for (int i = 0; i < BufDepth; i++)
      send_word(load_word(IdxW'(i), 8'($urandom_range(255))));

    // Directed corner cases
    send_word(load_word(5'd0, 8'h00));
    send_word(load_word(5'd31, 8'hFF));
    set_instr(7'h7F, 1'b1, 6'd1);
    send_word(event_word(ST_START));          // event while idle, address byte all ones
    send_word(event_word(ST_RX_NACK));        // last read byte, stop
    send_word(poll_word(1'b0));               // nothing pending: no start
    send_word(poll_word(1'b1));
    send_word(poll_word(1'b1));               // already busy: no second start
    set_instr(7'h00, 1'b0, 6'd0);
    send_word(event_word(ST_START));
    send_word(event_word(ST_SLAW_ACK));       // zero-length write still sends entry 0
    send_word(event_word(ST_TX_ACK));         // count past length ends the write
    set_instr(7'h2A, 1'b0, 6'd2);
    send_word(poll_word(1'b1));
    send_word(event_word(ST_SLAW_ACK));
    send_word(event_word(ST_TX_ACK));
    send_word(event_word(ST_TX_NACK));        // NACK on the last byte counts as done
    set_instr(7'h15, 1'b0, 6'd3);
    send_word(poll_word(1'b1));
    send_word(event_word(ST_SLAW_ACK));
    send_word(event_word(ST_TX_NACK));        // early data NACK
    send_word(event_word(ST_SLAW_NACK));
    send_word(event_word(ST_SLAR_NACK));
    set_instr(7'h55, 1'b1, 6'd63);            // length saturates at the store depth
    send_word(event_word(ST_SLAR_ACK));
    send_word(event_word(8'h00));             // unknown status
    send_word(event_word(8'hF8));
    w = rand_word();
    w.mode = MODE_SPARE;
    send_word(w);

    // Random transfers under three idle patterns
    random_phase(21, 46, 530);
    random_phase(46, 21, 530);
    random_phase(0, 0, 530);
    in_valid_i <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (words_waiting != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/i2cms_pkg.sv
rtl/core/i2c_master_transaction_sequencer_core.sv
test/i2cms_seq_checker.sv
test/i2c_master_transaction_sequencer_core_tb.sv
